@@ rtl/core/assert_macros.svh @@
// assertion macros used by the checker module lrbf_checker
// no dependencies; taken in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ON_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies the consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies the consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/lrbf_pkg.sv @@
// types and constants of the link reconnect backoff machine
// no dependencies; used by link_reconnect_backoff_fsm and lrbf_checker
`timescale 1ns / 1ps

package lrbf_pkg;

  // reconnect machine states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOST   = 4'b0010,
    ST_RECON  = 4'b0100,
    ST_WAIT   = 4'b1000
  } state_e;

  // link_state codes as reported in the result
  localparam logic [1:0] LS_IDLE  = 2'd0;
  localparam logic [1:0] LS_LOST  = 2'd1;
  localparam logic [1:0] LS_RECON = 2'd2;
  localparam logic [1:0] LS_WAIT  = 2'd3;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_MAX_RETRIES  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BACKOFF_LIM  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_INIT_BACKOFF = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LOST_DELAY   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_AUTO_AFTER   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_AUTO_BACKOFF = 3'd5;

  // register reset values
  localparam logic [7:0]  RST_MAX_RETRIES  = 8'd5;
  localparam logic [31:0] RST_BACKOFF_LIM  = 32'd300000;
  localparam logic [31:0] RST_INIT_BACKOFF = 32'd5000;
  localparam logic [31:0] RST_LOST_DELAY   = 32'd1000;
  localparam logic [31:0] RST_AUTO_AFTER   = 32'd3600000;
  localparam logic [31:0] RST_AUTO_BACKOFF = 32'd900000;

  // poll transaction, first field in the highest bits, last field in the lowest
  typedef struct packed {
    logic [6:0]  pad;
    logic [31:0] now_ms;
    logic        link_up;
  } poll_t;

  // result transaction, first field in the highest bits, last field in the lowest
  typedef struct packed {
    logic        pad;
    logic [31:0] successes;
    logic [31:0] attempts;
    logic [31:0] backoff_ms;
    logic [7:0]  retry_count;
    logic        autonomous;
    logic        autonomous_entered;
    logic        link_lost;
    logic        reconnected;
    logic        start_connect;
    logic [1:0]  link_state;
  } result_t;

  localparam int unsigned PollW   = $bits(poll_t);
  localparam int unsigned ResultW = $bits(result_t);

endpackage

@@ rtl/core/link_reconnect_backoff_fsm.sv @@
// link reconnect state machine with exponential backoff, top level
// depends on lrbf_pkg
`timescale 1ns / 1ps

// Usage
//   s_axis: one poll per transaction; tdata holds link_up (bit 0) and the
//   free-running millisecond time now_ms (bits 32:1).
//   m_axis: one result per poll, in poll order; tdata holds link_state,
//   the start_connect, reconnected, link_lost and autonomous_entered events,
//   the autonomous flag, retry_count, backoff_ms, attempts and successes.
//   cfg: register writes (index, 32-bit data), always ready; write only
//   while no poll is in flight. Indexes 6 and 7 are ignored.
// Pipeline
//   a poll passes from the input register to the result register and is
//   then offered on m_axis; one poll per cycle is sustained while m_axis is
//   ready. The machine state is updated as the poll moves from the input
//   register to the result register.
// Reset
//   rst_ni clears the valid bits of both pipeline registers, puts the machine in idle with a
//   5000 ms backoff and zero counters, and loads the register defaults.
// Stalls
//   while m_axis is held off the result register holds, the input register
//   still takes one more poll, then s_axis_tready falls.
module link_reconnect_backoff_fsm (
  input  logic         clk_i,
  input  logic         rst_ni,
  // poll input
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // link_up, now_ms[31:0], zero pad
  // result output
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,   // link_state[1:0], start_connect,
                                       // reconnected, link_lost,
                                       // autonomous_entered, autonomous,
                                       // retry_count[7:0], backoff_ms[31:0],
                                       // attempts[31:0], successes[31:0],
                                       // zero pad
  // configuration writes
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  // configuration registers
  logic [7:0]  max_retries_q;
  logic [31:0] backoff_lim_q, init_backoff_q, lost_delay_q, auto_after_q, auto_backoff_q;

  // pipeline registers
  logic                 in_vld_q, out_vld_q;
  lrbf_pkg::poll_t      in_q;
  lrbf_pkg::result_t    out_q, res_d;
  logic                 advance, in_take;

  // machine state
  lrbf_pkg::state_e state_q, state_d;
  logic [7:0]  retry_q, retry_d;
  logic [31:0] backoff_q, backoff_d;
  logic [31:0] loss_time_q, loss_time_d;
  logic        loss_vld_q, loss_vld_d;
  logic [31:0] retry_start_q, retry_start_d;
  logic        auto_q, auto_d;
  logic [31:0] attempts_q, attempts_d;
  logic [31:0] successes_q, successes_d;

  // per-poll intermediates
  logic [31:0] diff_loss, diff_retry, wait_ms;
  logic [7:0]  retry_inc;
  logic [32:0] backoff_dbl;
  logic        auto_enter;
  logic        ev_pulse, ev_back, ev_lost, ev_auto;
  logic [1:0]  state_code;

  // handshakes
  assign cfg_ready_o   = 1'b1;
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_retries_q  <= lrbf_pkg::RST_MAX_RETRIES;
      backoff_lim_q  <= lrbf_pkg::RST_BACKOFF_LIM;
      init_backoff_q <= lrbf_pkg::RST_INIT_BACKOFF;
      lost_delay_q   <= lrbf_pkg::RST_LOST_DELAY;
      auto_after_q   <= lrbf_pkg::RST_AUTO_AFTER;
      auto_backoff_q <= lrbf_pkg::RST_AUTO_BACKOFF;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lrbf_pkg::REG_MAX_RETRIES:  max_retries_q  <= cfg_data_i[7:0];
        lrbf_pkg::REG_BACKOFF_LIM:  backoff_lim_q  <= cfg_data_i;
        lrbf_pkg::REG_INIT_BACKOFF: init_backoff_q <= cfg_data_i;
        lrbf_pkg::REG_LOST_DELAY:   lost_delay_q   <= cfg_data_i;
        lrbf_pkg::REG_AUTO_AFTER:   auto_after_q   <= cfg_data_i;
        lrbf_pkg::REG_AUTO_BACKOFF: auto_backoff_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= lrbf_pkg::poll_t'(s_axis_tdata);
    end
  end

  // wrapped time differences, autonomous entry and the doubled backoff
  assign diff_loss   = in_q.now_ms - loss_time_q;
  assign diff_retry  = in_q.now_ms - retry_start_q;
  assign auto_enter  = !auto_q && loss_vld_q && (diff_loss > auto_after_q);
  assign retry_inc   = retry_q + 8'd1;
  assign backoff_dbl = {backoff_q, 1'b0};
  assign wait_ms     = (auto_q || auto_enter) ? auto_backoff_q : backoff_q;

  // next machine state for the poll in the input register
  always_comb begin
    state_d       = state_q;
    retry_d       = retry_q;
    backoff_d     = backoff_q;
    loss_time_d   = loss_time_q;
    loss_vld_d    = loss_vld_q;
    retry_start_d = retry_start_q;
    auto_d        = auto_q;
    attempts_d    = attempts_q;
    successes_d   = successes_q;
    ev_pulse      = 1'b0;
    ev_back       = 1'b0;
    ev_lost       = 1'b0;
    ev_auto       = 1'b0;
    if (in_q.link_up) begin
      // link present: return to idle if anything was pending
      if (state_q != lrbf_pkg::ST_IDLE) begin
        state_d     = lrbf_pkg::ST_IDLE;
        retry_d     = 8'd0;
        backoff_d   = init_backoff_q;
        loss_time_d = 32'd0;
        loss_vld_d  = 1'b0;
        auto_d      = 1'b0;
        successes_d = successes_q + 32'd1;
        ev_back     = 1'b1;
      end
    end else if (state_q == lrbf_pkg::ST_IDLE) begin
      // loss detected
      state_d       = lrbf_pkg::ST_LOST;
      loss_time_d   = in_q.now_ms;
      loss_vld_d    = 1'b1;
      retry_start_d = in_q.now_ms;
      ev_lost       = 1'b1;
    end else begin
      // long outage switches to autonomous mode
      if (auto_enter) begin
        auto_d  = 1'b1;
        ev_auto = 1'b1;
      end
      case (state_q)
        lrbf_pkg::ST_LOST: begin
          if (diff_retry >= lost_delay_q) begin
            state_d = lrbf_pkg::ST_RECON;
          end
        end
        lrbf_pkg::ST_RECON: begin
          ev_pulse = 1'b1;
          retry_d  = retry_inc;
          if (retry_inc > max_retries_q) begin
            backoff_d = (backoff_dbl > {1'b0, backoff_lim_q}) ? backoff_lim_q
                                                               : backoff_dbl[31:0];
            retry_d   = 8'd0;
          end
          retry_start_d = in_q.now_ms;
          state_d       = lrbf_pkg::ST_WAIT;
          attempts_d    = attempts_q + 32'd1;
        end
        lrbf_pkg::ST_WAIT: begin
          if (diff_retry >= wait_ms) begin
            state_d = lrbf_pkg::ST_RECON;
          end
        end
        default: ;
      endcase
    end
  end

  // reported state code
  always_comb begin
    case (state_d)
      lrbf_pkg::ST_IDLE:  state_code = lrbf_pkg::LS_IDLE;
      lrbf_pkg::ST_LOST:  state_code = lrbf_pkg::LS_LOST;
      lrbf_pkg::ST_RECON: state_code = lrbf_pkg::LS_RECON;
      lrbf_pkg::ST_WAIT:  state_code = lrbf_pkg::LS_WAIT;
      default:            state_code = lrbf_pkg::LS_IDLE;
    endcase
  end

  // result assembly
  always_comb begin
    res_d                    = '0;
    res_d.link_state         = state_code;
    res_d.start_connect      = ev_pulse;
    res_d.reconnected        = ev_back;
    res_d.link_lost          = ev_lost;
    res_d.autonomous_entered = ev_auto;
    res_d.autonomous         = auto_d;
    res_d.retry_count        = retry_d;
    res_d.backoff_ms         = backoff_d;
    res_d.attempts           = attempts_d;
    res_d.successes          = successes_d;
  end

  // machine state update, one poll per advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= lrbf_pkg::ST_IDLE;
      retry_q       <= 8'd0;
      backoff_q     <= lrbf_pkg::RST_INIT_BACKOFF;
      loss_time_q   <= 32'd0;
      loss_vld_q    <= 1'b0;
      retry_start_q <= 32'd0;
      auto_q        <= 1'b0;
      attempts_q    <= 32'd0;
      successes_q   <= 32'd0;
    end else if (advance) begin
      state_q       <= state_d;
      retry_q       <= retry_d;
      backoff_q     <= backoff_d;
      loss_time_q   <= loss_time_d;
      loss_vld_q    <= loss_vld_d;
      retry_start_q <= retry_start_d;
      auto_q        <= auto_d;
      attempts_q    <= attempts_d;
      successes_q   <= successes_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

endmodule

@@ rtl/core/lrbf_checker.sv @@
// port-level checks for link_reconnect_backoff_fsm, bound to the top level
// depends on lrbf_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lrbf_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [111:0] m_axis_tdata
);

  lrbf_pkg::result_t res;

  assign res = lrbf_pkg::result_t'(m_axis_tdata);

  // a stalled result transaction keeps its contents
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // connect, reconnect and loss events never coincide
  `ASSERT_ON_CLK(a_events, clk_i, rst_ni, !m_axis_tvalid || $onehot0({res.start_connect, res.reconnected, res.link_lost}), "conflicting events in one result")

  // a return of the link leaves a clean idle machine
  `ASSERT_IMPLY(a_back_idle, clk_i, rst_ni, m_axis_tvalid && res.reconnected, res.link_state == lrbf_pkg::LS_IDLE && res.retry_count == 8'd0 && !res.autonomous, "reconnect did not restore idle")

  // a detected loss reports the lost state
  `ASSERT_IMPLY(a_lost_state, clk_i, rst_ni, m_axis_tvalid && res.link_lost, res.link_state == lrbf_pkg::LS_LOST && !res.autonomous, "loss not reported as lost")

  // autonomous entry raises the mode flag and comes only on a down link
  `ASSERT_IMPLY(a_auto_flag, clk_i, rst_ni, m_axis_tvalid && res.autonomous_entered, res.autonomous && res.link_state != lrbf_pkg::LS_IDLE, "autonomous entry without mode flag")

endmodule

bind link_reconnect_backoff_fsm lrbf_checker u_lrbf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
